// ----- design/b58d_pkg.sv -----
package b58d_pkg;

    // Accumulator size in decimal digits (top-level default)
    localparam int MAX_DIGITS_DEF = 64;

    // Symbol queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SYM_W   = 8;
    localparam int INDEX_W = 6;
    localparam int DIGIT_W = 4;
    localparam int CARRY_W = 6;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_sym_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } t_back_state;

    // Bitcoin Base58 alphabet: character to index, unknown characters map to 0
    function automatic logic [INDEX_W-1:0] symbol_index(input logic [SYM_W-1:0] ch);
        logic [SYM_W-1:0] d;
        d = '0;
        if (ch >= 8'h31 && ch <= 8'h39) begin          // '1'..'9'
            d = ch - 8'h31;
        end else if (ch >= 8'h41 && ch <= 8'h48) begin // 'A'..'H'
            d = ch - 8'h41 + 8'd9;
        end else if (ch >= 8'h4A && ch <= 8'h4E) begin // 'J'..'N'
            d = ch - 8'h4A + 8'd17;
        end else if (ch >= 8'h50 && ch <= 8'h5A) begin // 'P'..'Z'
            d = ch - 8'h50 + 8'd22;
        end else if (ch >= 8'h61 && ch <= 8'h6B) begin // 'a'..'k'
            d = ch - 8'h61 + 8'd33;
        end else if (ch >= 8'h6D && ch <= 8'h7A) begin // 'm'..'z'
            d = ch - 8'h6D + 8'd44;
        end
        return d[INDEX_W-1:0];
    endfunction

endpackage

// ----- design/b58d_front.sv -----
module b58d_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [b58d_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_last_symbol,
    output logic                      o_entry_valid,
    output b58d_pkg::t_sym_entry      o_entry,
    input  logic                      i_pop
);

    b58d_pkg::t_sym_entry r_q [b58d_pkg::QUEUE_DEPTH];
    logic [b58d_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [b58d_pkg::QCNT_W-1:0] r_count;
    logic push, pop;

    assign o_s_axis_tready = (r_count != b58d_pkg::QCNT_W'(b58d_pkg::QUEUE_DEPTH));
    assign o_entry_valid   = (r_count != '0);
    assign o_entry         = r_q[r_rd_ptr];
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = i_pop && o_entry_valid;

    // classify on the way in, so the queue carries the 6-bit index and last flag, not the symbol
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr].index <= b58d_pkg::symbol_index(i_symbol);
            r_q[r_wr_ptr].last  <= i_last_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/b58d_back.sv -----
module b58d_back #(
    parameter int MAX_DIGITS = b58d_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_entry_valid,
    input  b58d_pkg::t_sym_entry         i_entry,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [b58d_pkg::DIGIT_W-1:0] o_digit,
    output logic                         o_last_digit,
    output logic                         o_overflow
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] LAST_UPD = CNT_W'(MAX_DIGITS - 1);

    b58d_pkg::t_back_state r_state, n_state;
    // circular digit line, position 0 holds the least significant digit at rest
    logic [b58d_pkg::DIGIT_W-1:0] r_dig [MAX_DIGITS];
    logic [b58d_pkg::DIGIT_W-1:0] n_dig [MAX_DIGITS];
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [b58d_pkg::CARRY_W-1:0] r_carry, n_carry;
    logic r_last, n_last;
    logic r_ovf, n_ovf;
    logic r_started, n_started;
    logic r_out_valid, n_out_valid;
    logic [b58d_pkg::DIGIT_W-1:0] r_out_digit, n_out_digit;
    logic r_out_last, n_out_last;
    logic r_out_ovf, n_out_ovf;

    // one digit step: t = d*58 + c = 50d + (8d + c)
    logic [7:0]  u;
    logic [15:0] u_prod;
    logic [3:0]  u_q;
    logic [7:0]  u_rem;
    logic [b58d_pkg::CARRY_W-1:0] step_carry;
    logic [b58d_pkg::DIGIT_W-1:0] step_digit;
    logic slot, lead;

    assign u          = {1'b0, r_dig[0], 3'b000} + 8'(r_carry);
    assign u_prod     = 16'(u) * 16'd205;            // u/10 exact for u < 1029
    assign u_q        = u_prod[14:11];
    assign u_rem      = u - ({4'b0, u_q} * 8'd10);
    assign step_digit = u_rem[b58d_pkg::DIGIT_W-1:0];
    assign step_carry = (b58d_pkg::CARRY_W'(r_dig[0]) * 6'd5) + b58d_pkg::CARRY_W'(u_q);

    assign slot = !r_out_valid || i_out_ready;
    assign lead = !r_started && (r_dig[MAX_DIGITS-1] == '0) && (r_cnt != CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_dig       = r_dig;
        n_cnt       = r_cnt;
        n_carry     = r_carry;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_digit = r_out_digit;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        o_pop       = 1'b0;
        case (r_state)
            b58d_pkg::ST_IDLE: begin
                if (i_entry_valid) begin
                    o_pop   = 1'b1;
                    n_carry = b58d_pkg::CARRY_W'(i_entry.index);
                    n_last  = i_entry.last;
                    n_cnt   = '0;
                    n_state = b58d_pkg::ST_UPDATE;
                end
            end
            b58d_pkg::ST_UPDATE: begin
                for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                    n_dig[i] = r_dig[i+1];
                end
                n_dig[MAX_DIGITS-1] = step_digit;
                n_carry = step_carry;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == LAST_UPD) begin
                    if (step_carry != '0) n_ovf = 1'b1;
                    if (r_last) begin
                        n_cnt     = MAX_CNT;
                        n_started = 1'b0;
                        n_state   = b58d_pkg::ST_EMIT;
                    end else begin
                        n_state = b58d_pkg::ST_IDLE;
                    end
                end
            end
            b58d_pkg::ST_EMIT: begin
                if (lead || slot) begin
                    // shift toward the top; zeros fill in, clearing the accumulator
                    for (int i = 1; i < MAX_DIGITS; i++) begin
                        n_dig[i] = r_dig[i-1];
                    end
                    n_dig[0] = '0;
                    n_cnt    = r_cnt - 1'b1;
                end
                if (!lead && slot) begin
                    n_out_valid = 1'b1;
                    n_out_digit = r_dig[MAX_DIGITS-1];
                    n_out_last  = (r_cnt == CNT_W'(1));
                    n_out_ovf   = r_ovf;
                    n_started   = 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_ovf     = 1'b0;
                        n_started = 1'b0;
                        n_state   = b58d_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = b58d_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b58d_pkg::ST_IDLE;
            r_dig       <= '{default: '0};
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dig       <= n_dig;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry     <= n_carry;
        r_last      <= n_last;
        r_out_digit <= n_out_digit;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit      = r_out_digit;
    assign o_last_digit = r_out_last;
    assign o_overflow   = r_out_ovf;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == b58d_pkg::ST_IDLE))
        else $error("symbol popped outside idle");

    a_new_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state == b58d_pkg::ST_EMIT))
        else $error("result produced outside emission");

    a_update_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b58d_pkg::ST_UPDATE) |-> (r_cnt < MAX_CNT))
        else $error("update pass overran the digit line");

    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b58d_pkg::ST_EMIT && n_state == b58d_pkg::ST_IDLE)
        |=> (!r_ovf && r_out_last))
        else $error("emission ended without final digit or flag clear");
`endif

endmodule

// ----- design/base58_to_decimal_decoder_top.sv -----
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tdata[7:0]=symbol, tlast=last_symbol
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata[3:0]=digit, tlast=last_digit,
//                                                  tuser[0]=overflow
//
// In the back end each symbol is first popped from the queue, then one digit of the
// decimal accumulator is folded per cycle (acc*58+index). A symbol marked last adds an
// emission pass (one digit line shift per cycle, leading zeros skipped without a transfer),
// which slows down while the output side stalls.
// A 4-entry symbol queue lets the input keep transferring while the back end works.
// Synchronous active-low reset clears the accumulator, overflow flag and queue.
module base58_to_decimal_decoder_top #(
    parameter int MAX_DIGITS = b58d_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] symbol
    input  logic       i_s_axis_tlast,   // last_symbol
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [3:0] digit, [7:4] zero
    output logic       o_m_axis_tlast,   // last_digit
    output logic       o_m_axis_tuser    // [0] overflow
);

    b58d_pkg::t_sym_entry entry;
    logic entry_valid;
    logic pop;
    logic [b58d_pkg::DIGIT_W-1:0] digit;

    // front: classify characters and queue their indexes
    b58d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_symbol        (i_s_axis_tdata),
        .i_last_symbol   (i_s_axis_tlast),
        .o_entry_valid   (entry_valid),
        .o_entry         (entry),
        .i_pop           (pop)
    );

    // back: digit-serial multiply-accumulate and decimal emission
    b58d_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (entry_valid),
        .i_entry       (entry),
        .o_pop         (pop),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_digit       (digit),
        .o_last_digit  (o_m_axis_tlast),
        .o_overflow    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'b0000, digit};

endmodule

// ----- tb/b58d_digit_checker.sv -----
`timescale 1ns / 1ps

module b58d_digit_checker #(
    parameter int MAX_DIGITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_sym_valid,
    input  logic       i_sym_ready,
    input  logic [7:0] i_sym_data,    // [7:0] symbol
    input  logic       i_sym_last,    // last_symbol
    input  logic       i_dig_valid,
    input  logic       i_dig_ready,
    input  logic [7:0] i_dig_data,    // [3:0] digit, [7:4] zero
    input  logic       i_dig_last,    // last_digit
    input  logic       i_dig_user,    // [0] overflow
    output int         o_mismatches,
    output int         o_digits_owed
);

    localparam int RADIX_IN     = 58;
    localparam int RADIX_OUT    = 10;
    localparam int REPORT_LIMIT = 10;
    localparam logic [8*58-1:0] B58_CHARS =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [3:0] digit;
        logic       last;
        logic       wrapped;
    } t_dec_digit;

    t_dec_digit digits_owed_q[$];
    logic [3:0] dec_acc [MAX_DIGITS];
    logic       acc_wrapped;
    int         mismatch_total = 0;

    initial begin
        o_mismatches  = 0;
        o_digits_owed = 0;
    end

    // position in the alphabet, anything else weighs as '1'
    function automatic logic [5:0] b58_weight(input logic [7:0] ch);
        for (int k = 0; k < RADIX_IN; k++) begin
            if (B58_CHARS[8*(RADIX_IN-1-k) +: 8] == ch) begin
                return 6'(k);
            end
        end
        return '0;
    endfunction

    task automatic clear_acc();
        for (int i = 0; i < MAX_DIGITS; i++) begin
            dec_acc[i] = '0;
        end
        acc_wrapped = 1'b0;
    endtask

    // acc = acc*58 + weight, mod 10^MAX_DIGITS; a terminating symbol unloads the number
    task automatic fold_symbol(input logic [7:0] ch, input logic terminal);
        int         carry;
        int         t;
        int         top;
        t_dec_digit d;
        carry = b58_weight(ch);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            t          = dec_acc[i] * RADIX_IN + carry;
            dec_acc[i] = 4'(t % RADIX_OUT);
            carry      = t / RADIX_OUT;
        end
        if (carry != 0) begin
            acc_wrapped = 1'b1;
        end
        if (terminal) begin
            top = MAX_DIGITS - 1;
            while (top > 0 && dec_acc[top] == 0) begin
                top--;
            end
            for (int i = top; i >= 0; i--) begin
                d.digit   = dec_acc[i];
                d.last    = (i == 0);
                d.wrapped = acc_wrapped;
                digits_owed_q.push_back(d);
            end
            clear_acc();
        end
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatch_total < REPORT_LIMIT) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatch_total++;
    endtask

    task automatic check_digit();
        t_dec_digit d;
        if (digits_owed_q.size() == 0) begin
            note_mismatch($sformatf("unexpected transfer tdata %h tlast %b tuser %b",
                                    i_dig_data, i_dig_last, i_dig_user));
        end else begin
            d = digits_owed_q.pop_front();
            if (i_dig_data != {4'b0000, d.digit} || i_dig_last != d.last ||
                i_dig_user != d.wrapped) begin
                note_mismatch($sformatf("exp digit %0d tlast %b tuser %b, got tdata %h tlast %b tuser %b",
                                        d.digit, d.last, d.wrapped,
                                        i_dig_data, i_dig_last, i_dig_user));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_acc();
            digits_owed_q.delete();
        end else begin
            if (i_dig_valid && i_dig_ready) begin
                check_digit();
            end
            if (i_sym_valid && i_sym_ready) begin
                fold_symbol(i_sym_data, i_sym_last);
            end
        end
        o_mismatches  <= mismatch_total;
        o_digits_owed <= digits_owed_q.size();
    end

endmodule

// ----- tb/tb_base58_to_decimal_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_base58_to_decimal_decoder_top;

    localparam int MAX_DIGITS   = b58d_pkg::MAX_DIGITS_DEF;
    localparam int RANDOM_ITEMS = 300;
    // Longest legal quiet stretch: four queued symbols, each swept through the back end,
    // a full emission behind a receiver stall, plus a long sender gap.
    localparam int QUIET_LIMIT  = 4000;
    // Settle time after the last expected digit, to catch stray transfers
    localparam int DRAIN_CYCLES = 2 * MAX_DIGITS + 16;
    localparam logic [8*58-1:0] B58_CHARS =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = '0;    // [7:0] symbol
    logic       i_s_axis_tlast  = 1'b0;  // last_symbol
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;          // [3:0] digit, [7:4] zero
    logic       o_m_axis_tlast;          // last_digit
    logic       o_m_axis_tuser;          // [0] overflow

    int mismatches;
    int digits_owed;
    int symbols_sent = 0;
    int burst_left   = 1;
    int rx_hold      = 0;
    int rx_roll;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    base58_to_decimal_decoder_top #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    b58d_digit_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sym_valid  (i_s_axis_tvalid),
        .i_sym_ready  (o_s_axis_tready),
        .i_sym_data   (i_s_axis_tdata),
        .i_sym_last   (i_s_axis_tlast),
        .i_dig_valid  (o_m_axis_tvalid),
        .i_dig_ready  (i_m_axis_tready),
        .i_dig_data   (o_m_axis_tdata),
        .i_dig_last   (o_m_axis_tlast),
        .i_dig_user   (o_m_axis_tuser),
        .o_mismatches (mismatches),
        .o_digits_owed(digits_owed)
    );

    // Receiver: open stretches, stall runs, and coin-flip cycles in between.
    // A new pattern is drawn whenever the current hold runs out.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 25) begin
                i_m_axis_tready <= 1'b1;
                rx_hold         <= $urandom_range(20, 120);
            end else if (rx_roll < 45) begin
                i_m_axis_tready <= 1'b0;
                rx_hold         <= $urandom_range(1, 24);
            end else begin
                i_m_axis_tready <= 1'($urandom_range(0, 1));
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_base58_to_decimal_decoder_top: errors");
        $finish;
    end

    function automatic logic [7:0] b58_char(input int idx);
        return B58_CHARS[8*(57-idx) +: 8];
    endfunction

    // One symbol transfer. tvalid stays high inside a burst; at the end of a
    // burst it drops for a random gap (none, short, or long enough to land
    // anywhere in the back end's per-symbol sweep).
    task automatic send_symbol(input logic [7:0] ch, input logic terminal);
        int gap;
        int roll;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= terminal;
        do @(posedge i_clk); while (!o_s_axis_tready);
        symbols_sent++;
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            roll       = $urandom_range(0, 99);
            if (roll < 30) begin
                gap = 0;
            end else if (roll < 85) begin
                gap = $urandom_range(1, 6);
            end else begin
                gap = $urandom_range(20, 80);
            end
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_symbol(s[i], i == s.len() - 1);
        end
    endtask

    // Random words: mostly clean alphabet strings, some long enough to wrap
    // the accumulator, some raw byte noise with stray tlast marks.
    task automatic send_random_word();
        int roll;
        int len;
        logic [7:0] ch;
        logic       terminal;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                ch       = 8'($urandom_range(0, 255));
                terminal = (i == len - 1) || ($urandom_range(0, 3) == 0);
                send_symbol(ch, terminal);
            end
        end else if (roll < 30) begin
            // 37+ high-weight symbols exceed 10^64
            len = $urandom_range(34, 44);
            for (int i = 0; i < len; i++) begin
                send_symbol(b58_char($urandom_range(30, 57)), i == len - 1);
            end
        end else begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                send_symbol(b58_char($urandom_range(0, 57)), i == len - 1);
            end
        end
    endtask

    initial begin
        int target;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero value, top symbol, non-alphabet bytes at both ends of
        // the byte range, a two-symbol value, the alphabet's gap neighbors,
        // look-alike characters that are not in the alphabet, leading zeros.
        send_text("1");
        send_text("z");
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);
        send_text("21");
        send_text("HJKkmn");
        send_text("0OIl9");
        send_text("111");

        target = symbols_sent + RANDOM_ITEMS;
        while (symbols_sent < target) begin
            send_random_word();
        end
        i_s_axis_tvalid <= 1'b0;

        // Wait for every owed digit, then let stray transfers show up
        do @(posedge i_clk); while (digits_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_base58_to_decimal_decoder_top: clean");
        end else begin
            $display("tb_base58_to_decimal_decoder_top: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/b58d_pkg.sv
design/b58d_front.sv
design/b58d_back.sv
design/base58_to_decimal_decoder_top.sv
tb/b58d_digit_checker.sv
tb/tb_base58_to_decimal_decoder_top.sv
